// ===== rtl/assert_macros.svh =====
// Assertion helpers used by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define PF_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every edge, reset included.
`define PF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pf_pkg.sv =====
package pf_pkg;

  localparam logic [7:0]  SYNC_HI      = 8'h55;
  localparam logic [7:0]  SYNC_LO      = 8'hAA;
  localparam logic [7:0]  TRAILER_PAD  = 8'h00;
  localparam logic [15:0] LEN_OVERHEAD = 16'd7;
  localparam int          NUM_SLOTS    = 8;

  // Byte positions of one item's output, in emission order.
  typedef enum logic [2:0] {
    SL_SYNC_HI,
    SL_SYNC_LO,
    SL_LEN_HI,
    SL_LEN_LO,
    SL_TYPE,
    SL_DATA,
    SL_PAD,
    SL_CSUM
  } pf_slot_t;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        has_payload;
    logic        first_of_packet;
    logic        last_of_packet;
    logic [7:0]  packet_type;
    logic [15:0] payload_length;
  } pf_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       end_of_run;
    logic       end_of_packet;
  } pf_out_t;

  // One classified item: which slots to emit and the bytes they need.
  typedef struct packed {
    logic [NUM_SLOTS-1:0] mask;
    logic [7:0]           len_hi;
    logic [7:0]           len_lo;
    logic [7:0]           ptype;
    logic [7:0]           data;
    logic [7:0]           csum;
  } pf_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } pf_qstat_t;

endpackage

// ===== rtl/pf_jobq.sv =====
module pf_jobq
  import pf_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pf_job_t   push_job,
  input  logic      pop,
  output pf_job_t   head_job,
  output pf_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pf_job_t            mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_job   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== rtl/pf_front.sv =====
module pf_front
  import pf_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_push,
  input  pf_in_t  in_data,
  input  logic    q_full,
  output logic    job_push,
  output pf_job_t job
);

  logic        in_packet_r, in_packet_nxt;
  logic [7:0]  xor_r, xor_nxt;
  logic [15:0] total;
  logic [7:0]  hdr_xor, base_xor, new_xor;
  logic        accept, active;

  assign accept  = in_push && !q_full;
  assign active  = in_data.first_of_packet || in_packet_r;
  assign total   = in_data.payload_length + LEN_OVERHEAD;
  assign hdr_xor = SYNC_HI ^ SYNC_LO ^ total[15:8] ^ total[7:0] ^ in_data.packet_type;
  assign base_xor = in_data.first_of_packet ? hdr_xor : xor_r;
  assign new_xor  = base_xor ^ (in_data.has_payload ? in_data.data_byte : 8'h00);

  always_comb begin
    job.mask   = {in_data.last_of_packet, in_data.last_of_packet, in_data.has_payload,
                  {5{in_data.first_of_packet}}} & {NUM_SLOTS{active}};
    job.len_hi = total[15:8];
    job.len_lo = total[7:0];
    job.ptype  = in_data.packet_type;
    job.data   = in_data.data_byte;
    job.csum   = new_xor;
  end

  // Items that emit nothing never reach the queue.
  assign job_push = accept && (job.mask != '0);

  always_comb begin
    in_packet_nxt = in_packet_r;
    xor_nxt       = xor_r;
    if (accept && active) begin
      in_packet_nxt = !in_data.last_of_packet;
      xor_nxt       = in_data.last_of_packet ? 8'h00 : new_xor;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r <= 1'b0;
      xor_r       <= 8'h00;
    end else begin
      in_packet_r <= in_packet_nxt;
      xor_r       <= xor_nxt;
    end
  end

endmodule

// ===== rtl/pf_back.sv =====
module pf_back
  import pf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  pf_job_t   job,
  input  pf_qstat_t q_stat,
  output logic      job_pop,
  output logic      out_empty,
  input  logic      out_pop,
  output pf_out_t   out_data
);

  logic [NUM_SLOTS-1:0] sent_r, sent_nxt;
  logic [NUM_SLOTS-1:0] remaining, cur_bit, rest;
  pf_slot_t             cur;
  logic                 job_last, advance;
  logic                 out_valid_r, out_valid_nxt;
  pf_out_t              out_r;
  logic [7:0]           cur_byte;

  assign remaining = job.mask & ~sent_r;

  // Lowest slot not yet sent.
  always_comb begin
    cur = SL_CSUM;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        cur = pf_slot_t'(3'(i));
      end
    end
  end

  assign cur_bit  = NUM_SLOTS'(1) << cur;
  assign rest     = remaining & ~cur_bit;
  assign job_last = (rest == '0);
  assign advance  = !q_stat.empty && (!out_valid_r || out_pop);
  assign job_pop  = advance && job_last;

  always_comb begin
    unique case (cur)
      SL_SYNC_HI: cur_byte = SYNC_HI;
      SL_SYNC_LO: cur_byte = SYNC_LO;
      SL_LEN_HI:  cur_byte = job.len_hi;
      SL_LEN_LO:  cur_byte = job.len_lo;
      SL_TYPE:    cur_byte = job.ptype;
      SL_DATA:    cur_byte = job.data;
      SL_PAD:     cur_byte = TRAILER_PAD;
      SL_CSUM:    cur_byte = job.csum;
    endcase
  end

  always_comb begin
    sent_nxt      = sent_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      sent_nxt      = job_last ? '0 : (sent_r | cur_bit);
      out_valid_nxt = 1'b1;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.out_byte      <= cur_byte;
      out_r.end_of_run    <= job_last;
      out_r.end_of_packet <= (cur == SL_CSUM);
    end
  end

  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/packet_framer_xor_lrc_unit.sv =====
// Serial packet framer with an 8-bit XOR check byte.
// Input queue side: in_data is taken when in_push is high and in_full low.
// An item with first_of_packet emits the header 55 AA len_hi len_lo type
// (length = payload_length + 7), an item with has_payload emits its byte,
// an item with last_of_packet emits 00 and the XOR of the packet's bytes.
// Items outside a packet without first_of_packet produce nothing.
// Output queue side: out_data is valid while out_empty is low and is
// transferred when out_pop is high.
// The first byte of an item passes the job queue, then the output register.
// Throughput: one output byte per cycle while out_pop stays high, set by the
// single output register; an item producing k bytes holds the back end until
// all k are sent, so one-byte payload items stream at one per cycle. A
// JOB_DEPTH deep queue between the classifier and the byte sequencer absorbs
// header and trailer bursts. When out_pop stays low the output byte holds;
// the queue fills and in_full rises after at most JOB_DEPTH more emitting
// items. Reset (rst_n low, synchronous) empties the queue and output and
// closes any open packet.
module packet_framer_xor_lrc_unit
  import pf_pkg::*;
#(
  parameter int JOB_DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_push,
  output logic    in_full,
  input  pf_in_t  in_data,
  output logic    out_empty,
  input  logic    out_pop,
  output pf_out_t out_data
);

  pf_job_t   fe_job, head_job;
  logic      fe_push, be_pop;
  pf_qstat_t q_stat;

  assign in_full = q_stat.full;

  pf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .q_full   (q_stat.full),
    .job_push (fe_push),
    .job      (fe_job)
  );

  pf_jobq #(
    .DEPTH (JOB_DEPTH)
  ) u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .push_job (fe_job),
    .pop      (be_pop),
    .head_job (head_job),
    .stat     (q_stat)
  );

  pf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (head_job),
    .q_stat    (q_stat),
    .job_pop   (be_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/pf_checker.sv =====
`include "assert_macros.svh"

module pf_checker
  import pf_pkg::*;
(
  input logic    clk,
  input logic    rst_n,
  input logic    in_full,
  input logic    out_empty,
  input logic    out_pop,
  input pf_out_t out_data
);

  `PF_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (out_empty && !in_full), "reset must empty both sides")

  `PF_ASSERT(a_out_hold, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "stalled output changed")

  `PF_ASSERT(a_eop_ends_run, clk, rst_n, (!out_empty && out_data.end_of_packet) |-> out_data.end_of_run, "check byte not last of its item")

endmodule

bind packet_framer_xor_lrc_unit pf_checker u_pf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

// ===== tb/packet_framer_xor_lrc_unit_tb.sv =====
`timescale 1ns / 100ps

module packet_framer_xor_lrc_unit_tb;
  import pf_pkg::*;

  localparam int RANDOM_ITEMS   = 370;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 20;

  logic    clk;
  logic    rst_n;
  logic    in_push;
  logic    in_full;
  pf_in_t  in_data;
  logic    out_empty;
  logic    out_pop;
  pf_out_t out_data;

  // framer model state
  logic [7:0] lrc_acc;
  logic       pkt_open;

  pf_out_t pending_bytes[$];
  int      fail_count;
  int      live_items;
  bit      idle_on;
  int      pop_stall;
  int      quiet_cycles;

  packet_framer_xor_lrc_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void put_wire_byte(input logic [7:0] b, input logic eop);
    pf_out_t r;
    r.out_byte      = b;
    r.end_of_run    = 1'b0;
    r.end_of_packet = eop;
    pending_bytes.push_back(r);
  endfunction

  // Expected wire bytes for one accepted item.
  function automatic void frame_item(input pf_in_t it);
    logic [15:0] total;
    int          n0;
    n0 = pending_bytes.size();
    if (it.first_of_packet) begin
      total   = it.payload_length + LEN_OVERHEAD;
      lrc_acc = SYNC_HI ^ SYNC_LO ^ total[15:8] ^ total[7:0] ^ it.packet_type;
      put_wire_byte(SYNC_HI, 1'b0);
      put_wire_byte(SYNC_LO, 1'b0);
      put_wire_byte(total[15:8], 1'b0);
      put_wire_byte(total[7:0], 1'b0);
      put_wire_byte(it.packet_type, 1'b0);
      pkt_open = 1'b1;
    end else if (!pkt_open) begin
      return;
    end
    live_items++;
    if (it.has_payload) begin
      lrc_acc = lrc_acc ^ it.data_byte;
      put_wire_byte(it.data_byte, 1'b0);
    end
    if (it.last_of_packet) begin
      put_wire_byte(TRAILER_PAD, 1'b0);
      put_wire_byte(lrc_acc, 1'b1);
      pkt_open = 1'b0;
      lrc_acc  = 8'h00;
    end
    if (pending_bytes.size() > n0)
      pending_bytes[pending_bytes.size()-1].end_of_run = 1'b1;
  endfunction

  function automatic pf_in_t make_item(input logic [7:0] d, input logic has,
                                       input logic first, input logic last,
                                       input logic [7:0] ptype, input logic [15:0] len);
    pf_in_t it;
    it.data_byte       = d;
    it.has_payload     = has;
    it.first_of_packet = first;
    it.last_of_packet  = last;
    it.packet_type     = ptype;
    it.payload_length  = len;
    return it;
  endfunction

  function automatic pf_in_t rand_item(input logic first, input logic last);
    logic [15:0] len;
    len = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 64));
    return make_item(8'($urandom), ($urandom_range(0, 5) != 0), first, last,
                     8'($urandom), len);
  endfunction

  // Called just after a rising edge; returns just after the transfer edge.
  task automatic send_item(input pf_in_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_full);
    frame_item(it);
  endtask

  // Result side: check on transfer, then pick the next pop value.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_pop && !out_empty) begin
        if (pending_bytes.size() == 0) begin
          $display("%0t: unexpected byte, expected none, actual byte=%02h run=%b eop=%b",
                   $time, out_data.out_byte, out_data.end_of_run, out_data.end_of_packet);
          fail_count++;
        end else begin
          if (out_data.out_byte !== pending_bytes[0].out_byte) begin
            $display("%0t: out_byte mismatch, expected %02h actual %02h", $time,
                     pending_bytes[0].out_byte, out_data.out_byte);
            fail_count++;
          end
          if (out_data.end_of_run !== pending_bytes[0].end_of_run) begin
            $display("%0t: end_of_run mismatch, expected %b actual %b", $time,
                     pending_bytes[0].end_of_run, out_data.end_of_run);
            fail_count++;
          end
          if (out_data.end_of_packet !== pending_bytes[0].end_of_packet) begin
            $display("%0t: end_of_packet mismatch, expected %b actual %b", $time,
                     pending_bytes[0].end_of_packet, out_data.end_of_packet);
            fail_count++;
          end
          void'(pending_bytes.pop_front());
        end
      end
      if (pop_stall > 0) begin
        pop_stall--;
        out_pop <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        pop_stall = $urandom_range(0, 2);
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_header_only();
    send_item(make_item(8'hFF, 1'b0, 1'b1, 1'b1, 8'h00, 16'd0));
    send_item(make_item(8'h00, 1'b0, 1'b1, 1'b1, 8'hFF, 16'd65528));
    // total length wraps past 16 bits
    send_item(make_item(8'h3C, 1'b0, 1'b1, 1'b1, 8'h5A, 16'hFFFF));
  endtask

  task automatic test_full_item();
    send_item(make_item(8'hFF, 1'b1, 1'b1, 1'b1, 8'hA5, 16'd1));
  endtask

  task automatic test_streamed_packet();
    send_item(make_item(8'h77, 1'b0, 1'b1, 1'b0, 8'h01, 16'd4));
    send_item(make_item(8'h00, 1'b1, 1'b0, 1'b0, 8'hFF, 16'hFFFF));
    send_item(make_item(8'hFF, 1'b1, 1'b0, 1'b0, 8'h00, 16'h0000));
    send_item(make_item(8'hA5, 1'b1, 1'b0, 1'b0, 8'h12, 16'h1234));
    send_item(make_item(8'h5A, 1'b1, 1'b0, 1'b1, 8'h34, 16'h5678));
  endtask

  task automatic test_idle_items();
    send_item(make_item(8'hFF, 1'b1, 1'b0, 1'b0, 8'hFF, 16'hFFFF));
    send_item(make_item(8'h00, 1'b0, 1'b0, 1'b1, 8'h00, 16'h0000));
    send_item(make_item(8'h81, 1'b1, 1'b0, 1'b1, 8'h81, 16'h8001));
  endtask

  task automatic test_abandoned_packet();
    send_item(make_item(8'h11, 1'b1, 1'b1, 1'b0, 8'h22, 16'd3));
    send_item(make_item(8'h33, 1'b1, 1'b0, 1'b0, 8'h00, 16'd0));
    send_item(make_item(8'h44, 1'b1, 1'b1, 1'b0, 8'h66, 16'd2));
    send_item(make_item(8'h55, 1'b1, 1'b0, 1'b1, 8'h00, 16'd0));
  endtask

  task automatic test_silent_items();
    send_item(make_item(8'h9C, 1'b0, 1'b1, 1'b0, 8'hC3, 16'd0));
    // open packet, nothing to emit
    send_item(make_item(8'hE7, 1'b0, 1'b0, 1'b0, 8'h7E, 16'd9));
    send_item(make_item(8'h18, 1'b0, 1'b0, 1'b1, 8'h81, 16'd0));
  endtask

  task automatic test_random_packets(input int target);
    int n_mid;
    while (live_items < target) begin
      if (live_items > target - 60)
        idle_on = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        send_item(rand_item(1'($urandom), 1'($urandom)));
      end else if ($urandom_range(0, 7) == 0) begin
        send_item(rand_item(1'b1, 1'b1));
      end else begin
        n_mid = $urandom_range(0, 6);
        send_item(rand_item(1'b1, 1'b0));
        repeat (n_mid) send_item(rand_item(1'b0, 1'b0));
        // now and then leave the packet open so the next header abandons it
        if ($urandom_range(0, 9) != 0)
          send_item(rand_item(1'b0, 1'b1));
      end
    end
  endtask

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_data      = '0;
    out_pop      = 1'b0;
    lrc_acc      = 8'h00;
    pkt_open     = 1'b0;
    fail_count   = 0;
    live_items   = 0;
    idle_on      = 1'b1;
    pop_stall    = 0;
    quiet_cycles = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_header_only();
    test_full_item();
    test_streamed_packet();
    test_idle_items();
    test_abandoned_packet();
    test_silent_items();
    test_random_packets(RANDOM_ITEMS);

    in_push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== packet_framer_xor_lrc_unit.f =====
+incdir+rtl
rtl/pf_pkg.sv
rtl/pf_jobq.sv
rtl/pf_front.sv
rtl/pf_back.sv
rtl/packet_framer_xor_lrc_unit.sv
rtl/pf_checker.sv
tb/packet_framer_xor_lrc_unit_tb.sv
